// File: hdl/rrfb_pkg.sv
`timescale 1ns / 1ps

package rrfb_pkg;

  // coordinate arithmetic width: holds rect_x + rect_width and friends, signed
  localparam int COORD_W = 15;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int COLOR_W     = 32;
  localparam int PIX_W       = 12;

  localparam int DEFAULT_MAX_DIM = 4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_SIZE   = 3'd0,
    REG_RECT_X        = 3'd1,
    REG_RECT_Y        = 3'd2,
    REG_RECT_WIDTH    = 3'd3,
    REG_RECT_HEIGHT   = 3'd4,
    REG_FILL_COLOR    = 3'd5,
    REG_CORNER_COLORS = 3'd6,
    REG_MODE          = 3'd7
  } cfg_reg_t;

endpackage

// File: hdl/rounded_rect_fill_blit_pixel.sv
`timescale 1ns / 1ps

// Clipped rectangle fill / blit, one destination pixel per word.
// Input channel: in_valid / in_stall with pixel_x, pixel_y and source_pixel
// (the source color the feeder fetched at the matching offset).
// Output channel: out_valid / out_stall with write_enable, pixel_color and
// is_corner, exactly one output word for every input word, in order.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index; only
// write while no word is in flight.
// A word passes an input register, the coverage and corner compares,
// then the output register. Throughput is one word per cycle while
// in_stall is low; a new word is taken while a finished one still waits
// at the output. When out_stall is high the output word holds; in_stall
// rises only once both registers are full, and drops in the cycle the
// output is taken. Reset (rst, synchronous) empties both registers and
// clears every configuration register to zero.
module rounded_rect_fill_blit_pixel #(
  parameter int MAX_DIM = rrfb_pkg::DEFAULT_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [rrfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rrfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rrfb_pkg::PIX_W-1:0]       pixel_x,
  input  logic [rrfb_pkg::PIX_W-1:0]       pixel_y,
  input  logic [rrfb_pkg::COLOR_W-1:0]     source_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             write_enable,
  output logic [rrfb_pkg::COLOR_W-1:0]     pixel_color,
  output logic                             is_corner
);
  import rrfb_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t MaxDimC = coord_t'(MAX_DIM);

  // configuration registers
  logic [28:0]        screen_size;
  logic [11:0]        rect_x;
  logic signed [12:0] rect_y;
  logic [12:0]        rect_width;
  logic [12:0]        rect_height;
  logic [31:0]        fill_color;
  logic [63:0]        corner_colors;
  logic [1:0]         mode;

  // input register
  logic               v1;
  logic [PIX_W-1:0]   px1;
  logic [PIX_W-1:0]   py1;
  logic [COLOR_W-1:0] src1;

  logic s2_ready;
  logic s1_ready;

  logic               we_next;
  logic [COLOR_W-1:0] color_next;
  logic               corner_next;

  assign s2_ready = !out_valid || !out_stall;
  assign s1_ready = !v1 || s2_ready;
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_size   <= '0;
      rect_x        <= '0;
      rect_y        <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      fill_color    <= '0;
      corner_colors <= '0;
      mode          <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_SIZE:   screen_size   <= cfg_data[28:0];
        REG_RECT_X:        rect_x        <= cfg_data[11:0];
        REG_RECT_Y:        rect_y        <= cfg_data[12:0];
        REG_RECT_WIDTH:    rect_width    <= cfg_data[12:0];
        REG_RECT_HEIGHT:   rect_height   <= cfg_data[12:0];
        REG_FILL_COLOR:    fill_color    <= cfg_data[31:0];
        REG_CORNER_COLORS: corner_colors <= cfg_data;
        REG_MODE:          mode          <= cfg_data[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= in_valid;
    end
    if (s1_ready && in_valid) begin
      px1  <= pixel_x;
      py1  <= pixel_y;
      src1 <= source_pixel;
    end
  end

  always_comb begin
    coord_t w;
    coord_t h;
    coord_t dx;
    coord_t dy;
    coord_t sw;
    coord_t sh;
    coord_t cw;
    coord_t ch;
    coord_t pxs;
    coord_t pys;
    coord_t dx1;
    coord_t dy1;
    coord_t rx1;
    coord_t rx2;
    coord_t by1;
    coord_t by2;
    logic   top_ok;
    logic   right_ok;
    logic   bot_ok;
    logic   off;
    logic   on_screen;
    logic   covered;
    logic   hit;
    logic [COLOR_W-1:0] cval;
    logic [COLOR_W-1:0] outer;
    logic [COLOR_W-1:0] inner;

    w  = coord_t'(screen_size[12:0]);
    h  = coord_t'(screen_size[28:16]);
    if (w > MaxDimC) w = MaxDimC;
    if (h > MaxDimC) h = MaxDimC;
    dx  = coord_t'(rect_x);
    dy  = coord_t'(rect_y);
    sw  = coord_t'(rect_width);
    sh  = coord_t'(rect_height);
    pxs = coord_t'(px1);
    pys = coord_t'(py1);
    outer = corner_colors[31:0];
    inner = corner_colors[63:32];

    off    = (dx >= w) || (dy >= h);
    top_ok = 1'b1;
    if (dy < 0) begin
      sh     = sh + dy;
      dy     = '0;
      top_ok = 1'b0;
    end
    off = off || (sh < 0);

    right_ok = !((sw + dx) > w);
    bot_ok   = !((sh + dy) > h);
    cw = right_ok ? sw : (w - dx);
    ch = bot_ok ? sh : (h - dy);

    covered = pxs >= dx && pxs < dx + cw && pys >= dy && pys < dy + ch;

    // corner pixels off screen are dropped; pixel coordinates are never negative
    on_screen = pxs < w && pys < h;
    dx1 = dx + coord_t'(1);
    dy1 = dy + coord_t'(1);
    rx1 = dx + sw - coord_t'(1);
    rx2 = dx + sw - coord_t'(2);
    by1 = dy + sh - coord_t'(1);
    by2 = dy + sh - coord_t'(2);

    // later corners win: test in reverse order
    hit  = 1'b1;
    cval = '0;
    priority if (bot_ok && right_ok && pxs == rx2 && pys == by1) cval = inner;
    else if (bot_ok && right_ok && pxs == rx1 && pys == by1)     cval = outer;
    else if (bot_ok && right_ok && pxs == rx1 && pys == by2)     cval = inner;
    else if (bot_ok && pxs == dx1 && pys == by1)                 cval = inner;
    else if (bot_ok && pxs == dx && pys == by1)                  cval = outer;
    else if (bot_ok && pxs == dx && pys == by2)                  cval = inner;
    else if (top_ok && right_ok && pxs == rx1 && pys == dy1)     cval = inner;
    else if (top_ok && right_ok && pxs == rx1 && pys == dy)      cval = outer;
    else if (top_ok && right_ok && pxs == rx2 && pys == dy)      cval = inner;
    else if (top_ok && pxs == dx && pys == dy1)                  cval = inner;
    else if (top_ok && pxs == dx1 && pys == dy)                  cval = inner;
    else if (top_ok && pxs == dx && pys == dy)                   cval = outer;
    else                                                         hit  = 1'b0;
    hit = hit && mode[1] && on_screen && !off;

    we_next     = 1'b0;
    color_next  = '0;
    corner_next = 1'b0;
    if (hit) begin
      we_next     = 1'b1;
      color_next  = cval;
      corner_next = 1'b1;
    end else if (covered && !off) begin
      we_next    = 1'b1;
      color_next = mode[0] ? src1 : fill_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= v1;
    end
    if (s2_ready && v1) begin
      write_enable <= we_next;
      pixel_color  <= color_next;
      is_corner    <= corner_next;
    end
  end

endmodule

// File: hdl/rrfb_checker.sv
`timescale 1ns / 1ps

module rrfb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             write_enable,
  input logic [rrfb_pkg::COLOR_W-1:0]     pixel_color,
  input logic                             is_corner
);
  import rrfb_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_color)
      && $stable(write_enable) && $stable(is_corner))
    else $error("stalled output word changed");

  // a skipped pixel carries zero fields
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> pixel_color == '0 && !is_corner)
    else $error("unwritten pixel with nonzero fields");

  a_corner_writes: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_corner |-> write_enable)
    else $error("corner color without write");

  // with the output register empty the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

endmodule

bind rounded_rect_fill_blit_pixel rrfb_checker u_rrfb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .write_enable (write_enable),
  .pixel_color  (pixel_color),
  .is_corner    (is_corner)
);
